>>> hdl/cst_pkg.sv
package cst_pkg;

	// operation codes
	localparam logic [2:0] OP_ADD_USER    = 3'd0;
	localparam logic [2:0] OP_SET_ADMIN   = 3'd1;
	localparam logic [2:0] OP_CHECK_ADMIN = 3'd2;
	localparam logic [2:0] OP_CHECK_USER  = 3'd3;
	localparam logic [2:0] OP_REMOVE_USER = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMATCH = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_ZERO    = 2'd3;

	// ascii '0', rejected in any key byte
	localparam logic [7:0] ZERO_CHAR = 8'h30;

	localparam int KEY_W = 32;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DRAIN,
		S_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture request
		logic clr;         // write zero at scan counter, advance
		logic scan_start;  // set scan counter to first slot
		logic scan;        // issue read at scan counter, advance
		logic imm_done;    // take result that needs no scan
		logic finish;      // take result from scanned slot
		logic out_load;    // move result into output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;    // counter at last slot
		logic scan_last;   // counter at last slot of this scan
		logic imm;         // request resolved without scan
		logic hit;         // slot read last cycle decides the request
		logic out_free;    // output register can take a result
	} dp_stat_t;

endpackage

>>> hdl/cst_ram.sv
module cst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/cst_ctrl.sv
module cst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cst_pkg::dp_stat_t  dp_stat,
	output cst_pkg::dp_cmd_t   dp_cmd
);

	cst_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cst_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cst_pkg::S_CLEAR: begin
				if (dp_stat.clr_last) state_d = cst_pkg::S_IDLE;
			end
			cst_pkg::S_IDLE: begin
				if (in_valid) state_d = cst_pkg::S_DISPATCH;
			end
			cst_pkg::S_DISPATCH: begin
				state_d = dp_stat.imm ? cst_pkg::S_FIN : cst_pkg::S_SCAN;
			end
			cst_pkg::S_SCAN: begin
				if (dp_stat.hit) state_d = cst_pkg::S_FIN;
				else if (dp_stat.scan_last) state_d = cst_pkg::S_DRAIN;
			end
			cst_pkg::S_DRAIN: begin
				state_d = cst_pkg::S_FIN;
			end
			cst_pkg::S_FIN: begin
				if (dp_stat.out_free) state_d = cst_pkg::S_IDLE;
			end
			default: begin
				state_d = cst_pkg::S_CLEAR;
			end
		endcase
	end

	always_comb begin
		dp_cmd   = '0;
		in_ready = 1'b0;
		case (state_q)
			cst_pkg::S_CLEAR: begin
				dp_cmd.clr = 1'b1;
			end
			cst_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				dp_cmd.load = in_valid;
			end
			cst_pkg::S_DISPATCH: begin
				dp_cmd.imm_done   = dp_stat.imm;
				dp_cmd.scan_start = !dp_stat.imm;
			end
			cst_pkg::S_SCAN: begin
				dp_cmd.finish = dp_stat.hit;
				dp_cmd.scan   = !dp_stat.hit;
			end
			cst_pkg::S_DRAIN: begin
				dp_cmd.finish = 1'b1;
			end
			cst_pkg::S_FIN: begin
				dp_cmd.out_load = dp_stat.out_free;
			end
			default: begin
				dp_cmd = '0;
			end
		endcase
	end

endmodule

>>> hdl/cst_dp.sv
module cst_dp #(
	parameter int SLOT_COUNT = 256,
	parameter int KEY_BYTES  = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [2:0]                  opcode,
	input  logic [cst_pkg::KEY_W-1:0]   user_name,
	input  logic [cst_pkg::KEY_W-1:0]   pass_word,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [1:0]                  status,
	output logic [7:0]                  slot_index,
	input  cst_pkg::dp_cmd_t            dp_cmd,
	output cst_pkg::dp_stat_t           dp_stat
);

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int KEY_LEN = (KEY_BYTES >= 4) ? 4 : KEY_BYTES;
	localparam logic [cst_pkg::KEY_W-1:0] KEY_MASK = (KEY_LEN >= 4) ? '1 :
		cst_pkg::KEY_W'((64'd1 << (8 * KEY_LEN)) - 64'd1);
	localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

	logic [2:0]                op_q;
	logic [cst_pkg::KEY_W-1:0] nm_q, pw_q;
	logic [AW-1:0]             cnt_q;
	logic [AW-1:0]             addr_s1;
	logic                      vld_s1;
	logic [1:0]                res_status_q;
	logic [7:0]                res_idx_q;
	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [7:0]                slot_index_q;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [2*cst_pkg::KEY_W-1:0] ram_wdata, ram_rdata;
	logic [cst_pkg::KEY_W-1:0] rd_nm, rd_pw;
	logic                      zero_char, match, empty, decide;

	cst_ram #(
		.WIDTH(2 * cst_pkg::KEY_W),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	assign rd_nm = ram_rdata[cst_pkg::KEY_W-1:0];
	assign rd_pw = ram_rdata[2*cst_pkg::KEY_W-1:cst_pkg::KEY_W];

	// masked-off bytes are zero, so all four bytes can be tested
	always_comb begin
		zero_char = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (nm_q[8*i +: 8] == cst_pkg::ZERO_CHAR) zero_char = 1'b1;
			if (pw_q[8*i +: 8] == cst_pkg::ZERO_CHAR) zero_char = 1'b1;
		end
	end

	assign match = (rd_nm == nm_q) && (rd_pw == pw_q);
	assign empty = (rd_nm[7:0] == 8'd0);

	always_comb begin
		case (op_q)
			cst_pkg::OP_ADD_USER:    decide = empty;
			cst_pkg::OP_CHECK_ADMIN: decide = match;
			default:                 decide = !empty && match;
		endcase
	end

	always_comb begin
		dp_stat.clr_last  = (cnt_q == LAST);
		dp_stat.scan_last = (op_q == cst_pkg::OP_CHECK_ADMIN) ? (cnt_q == '0)
			: (cnt_q == LAST);
		dp_stat.imm       = zero_char || !(op_q inside {cst_pkg::OP_ADD_USER,
			cst_pkg::OP_CHECK_ADMIN, cst_pkg::OP_CHECK_USER,
			cst_pkg::OP_REMOVE_USER});
		dp_stat.hit       = vld_s1 && decide;
		dp_stat.out_free  = !out_valid_q || out_ready;
	end

	// write port: clearing sweep, admin set, user add, user remove
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		if (dp_cmd.clr) begin
			ram_we = 1'b1;
		end else if (dp_cmd.imm_done && !zero_char && op_q == cst_pkg::OP_SET_ADMIN) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = {pw_q, nm_q};
		end else if (dp_cmd.finish && dp_stat.hit) begin
			ram_waddr = addr_s1;
			if (op_q == cst_pkg::OP_ADD_USER) begin
				ram_we    = 1'b1;
				ram_wdata = {pw_q, nm_q};
			end else if (op_q == cst_pkg::OP_REMOVE_USER) begin
				ram_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= dp_cmd.scan;
			if (dp_cmd.clr || dp_cmd.scan) begin
				cnt_q <= cnt_q + AW'(1);
			end else if (dp_cmd.scan_start) begin
				cnt_q <= (op_q == cst_pkg::OP_CHECK_ADMIN) ? '0 : AW'(1);
			end
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			op_q <= opcode;
			nm_q <= user_name & KEY_MASK;
			pw_q <= pass_word & KEY_MASK;
		end
		if (dp_cmd.scan) begin
			addr_s1 <= cnt_q;
		end
		if (dp_cmd.imm_done) begin
			res_idx_q <= '0;
			if (zero_char) res_status_q <= cst_pkg::ST_ZERO;
			else if (op_q == cst_pkg::OP_SET_ADMIN) res_status_q <= cst_pkg::ST_OK;
			else res_status_q <= cst_pkg::ST_NOMATCH;
		end else if (dp_cmd.finish) begin
			if (dp_stat.hit) begin
				res_status_q <= cst_pkg::ST_OK;
				res_idx_q    <= 8'(addr_s1);
			end else begin
				res_status_q <= (op_q == cst_pkg::OP_ADD_USER) ? cst_pkg::ST_FULL
					: cst_pkg::ST_NOMATCH;
				res_idx_q    <= '0;
			end
		end
		if (dp_cmd.out_load) begin
			status_q     <= res_status_q;
			slot_index_q <= res_idx_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_index_q;

endmodule

>>> hdl/credential_slot_table_core.sv
// credential slot table: slot 0 holds the admin, slots 1 and up hold users
// input channel: in_valid / in_ready carry one request beat (opcode, user_name,
//   pass_word); in_ready is high only while the block is idle, one request at a time
// output channel: out_valid / out_ready carry one result beat (status, slot_index)
//   per request, held in an output register until taken
// scan: add user, check user and remove user scan the slot memory one read a
//   cycle from slot 1 up and stop early at the first deciding slot; check admin
//   reads slot 0 only, while set admin and rejected requests need no scan
// the scan rate is set by the single read port of the slot memory, one slot per cycle
// reset: arst_n clears control state, then a clearing pass writes zero to every
//   slot, during which in_ready stays low
// stall: while out_ready is low the finished result waits in the output register
//   and the next request waits at its final step until the register frees
module credential_slot_table_core #(
	parameter int SLOT_COUNT = 256,
	parameter int KEY_BYTES  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [31:0] user_name,
	input  logic [31:0] pass_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  slot_index
);

	// command and status between sequencer and datapath
	cst_pkg::dp_cmd_t  dp_cmd;
	cst_pkg::dp_stat_t dp_stat;

	// sequencer: clearing pass, dispatch, scan, drain, result handoff
	cst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.dp_stat  (dp_stat),
		.dp_cmd   (dp_cmd)
	);

	// datapath: request registers, slot memory, compare, result registers
	cst_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.KEY_BYTES  (KEY_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (opcode),
		.user_name  (user_name),
		.pass_word  (pass_word),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.slot_index (slot_index),
		.dp_cmd     (dp_cmd),
		.dp_stat    (dp_stat)
	);

endmodule
